>>> rtl/spa_pkg.sv
package spa_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DIV   = 3'd3,
        OP_NEG   = 3'd4,
        OP_EVAL  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_DIVZERO  = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

    // Width of the CORDIC x and y datapath, signed.
    localparam int XW = 36;
    // Width of a gain-compensated amplitude.
    localparam int CW = 30;
    // Extra fraction bits carried through the CORDIC.
    localparam int GUARD = 6;
    // Divisor width of the amplitude divider.
    localparam int DIV_W = 24;

    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam logic [63:0] RECIP_TWO_PI = 64'h28BE60DB9391054A;
    localparam logic [23:0] AMP_MAX = 24'hFFFFFF;
    localparam logic [31:0] HALF_TURN = 32'h80000000;
    localparam logic signed [31:0] QUARTER_TURN = 32'sh40000000;
    localparam logic signed [31:0] NEG_QUARTER_TURN = 32'shC0000000;

    // Side information that travels with every item down the pipeline.
    typedef struct packed {
        op_t                op;
        logic [23:0]        amp_a;
        logic [23:0]        freq_a;
        logic [15:0]        phase_a;
        logic               mismatch;
        logic               neg_factor;
        logic               amp_a_nz;
        logic               mag_zero;
        logic [23:0]        scale_amp;
        logic               scale_sat;
        logic signed [24:0] sample;
        logic               sample_sat;
        logic               sum_zero;
    } side_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/spa_rot_stage.sv
// One rotation-mode CORDIC iteration, registered.
module spa_rot_stage
    import spa_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic [31:0]          z_in,
    output logic signed [XW-1:0] x_reg,
    output logic signed [XW-1:0] y_reg,
    output logic [31:0]          z_reg
);

    logic signed [XW-1:0] xs, ys, x_next, y_next;
    logic [31:0]          z_next;

    always_comb begin
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        if (!z_in[31]) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - atan_angle(5'(IDX));
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + atan_angle(5'(IDX));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

>>> rtl/spa_vec_stage.sv
// One vectoring-mode CORDIC iteration, registered.
module spa_vec_stage
    import spa_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic [31:0]          z_in,
    output logic signed [XW-1:0] x_reg,
    output logic signed [XW-1:0] y_reg,
    output logic [31:0]          z_reg
);

    logic signed [XW-1:0] xs, ys, x_next, y_next;
    logic [31:0]          z_next;

    always_comb begin
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        if (!y_in[XW-1]) begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + atan_angle(5'(IDX));
        end else begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - atan_angle(5'(IDX));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

>>> rtl/spa_div_stage.sv
// BPS restoring division steps, registered. The numerator shifts out of the
// top of nq while quotient bits shift in at the bottom.
module spa_div_stage
    import spa_pkg::*;
#(
    parameter int QB  = 42,
    parameter int BPS = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DIV_W-1:0] rem_in,
    input  logic [QB-1:0]    nq_in,
    input  logic [DIV_W-1:0] d_in,
    output logic [DIV_W-1:0] rem_reg,
    output logic [QB-1:0]    nq_reg,
    output logic [DIV_W-1:0] d_reg
);

    logic [DIV_W-1:0] rem_next;
    logic [QB-1:0]    nq_next;
    logic [DIV_W:0]   trial;

    always_comb begin
        rem_next = rem_in;
        nq_next  = nq_in;
        trial    = '0;
        for (int b = 0; b < BPS; b++) begin
            trial   = {rem_next, nq_next[QB-1]};
            nq_next = {nq_next[QB-2:0], 1'b0};
            if (trial >= {1'b0, d_in}) begin
                rem_next   = DIV_W'(trial - {1'b0, d_in});
                nq_next[0] = 1'b1;
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            d_reg   <= d_in;
        end
    end

endmodule

>>> rtl/sinusoid_phasor_arithmetic.sv
// Sinusoid phasor arithmetic. Each beat on the s_ channel carries an operation
// and one or two sinusoids A*sin(w*t+phi); each beat on the m_ channel returns
// exactly one result in the same order. The block is a single pipeline that
// takes a new beat in every cycle and delivers one result per cycle when the
// output side keeps m_ready high. An accepted beat passes through stages 1
// to 5, the chain of rotation CORDIC, vector CORDIC and the multipliers around
// them, and the output register; the amplitude divider runs alongside the main
// chain BPS quotient bits at a time. When m_valid is high and m_ready is low
// the whole pipeline holds and s_ready falls, so nothing is lost or repeated.
// Add and subtract need equal frequencies (status 1 otherwise), divide by a
// zero factor gives status 2, and an amplitude or sample that overflows
// saturates with status 3. Phases are 16-bit binary angles in which 32768
// stands for pi.
module sinusoid_phasor_arithmetic
    import spa_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic [23:0]        s_amp_a,
    input  logic [23:0]        s_freq_a,
    input  logic signed [15:0] s_phase_a,
    input  logic [23:0]        s_amp_b,
    input  logic [23:0]        s_freq_b,
    input  logic signed [15:0] s_phase_b,
    input  logic signed [23:0] s_factor,
    input  logic [31:0]        s_time_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_amp_out,
    output logic [23:0]        m_freq_out,
    output logic signed [15:0] m_phase_out,
    output logic signed [24:0] m_sample_value,
    output logic [1:0]         m_status
);

    localparam int N        = CORDIC_STAGES;
    localparam int NUMW     = 25 + FRAC_BITS;
    localparam int DIV_ST   = 2 * N + 3;
    localparam int BPS      = (NUMW + DIV_ST - 1) / DIV_ST;
    localparam int QB       = BPS * DIV_ST;
    localparam int TURN_LSB = FRAC_BITS + 48;
    localparam int PW       = 120;

    // The pipeline moves whenever the output register is free or being taken.
    // No beat is taken while reset is held, since the valid bits are cleared then.
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en && aresetn;

    // ------------------------------------------------------------------
    // Stage 1: decode, gain compensation, frequency-time product, scale
    // product and divider numerator.
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    side_t             s1_side_reg, s1_side_next;
    logic [CW-1:0]     s1_comp_a_reg, s1_comp_b_reg, s1_comp_a_next, s1_comp_b_next;
    logic [15:0]       s1_phase_b_reg, s1_phase_b_next;
    logic [55:0]       s1_ftp_reg;
    logic [47:0]       s1_sprod_reg;
    logic [NUMW-1:0]   s1_num_reg, s1_num_next;
    logic [23:0]       s1_mag_reg, s1_mag_next;
    logic [59:0]       comp_a_prod, comp_b_prod;

    always_comb begin
        s1_mag_next  = s_factor[23] ? 24'(~s_factor + 24'sd1) : s_factor;
        comp_a_prod  = 60'({s_amp_a, 6'b0}) * 60'(INV_GAIN);
        comp_b_prod  = 60'({s_amp_b, 6'b0}) * 60'(INV_GAIN);
        s1_comp_a_next = comp_a_prod[59:30];
        s1_comp_b_next = comp_b_prod[59:30];
        s1_phase_b_next = s_phase_b;
        if (op_t'(s_operation) == OP_SUB && s_amp_b != 24'd0) begin
            s1_phase_b_next = s_phase_b ^ 16'h8000;
        end
        s1_num_next = NUMW'({s_amp_a, {FRAC_BITS{1'b0}}}) + NUMW'(s1_mag_next >> 1);

        s1_side_next            = '0;
        s1_side_next.op         = op_t'(s_operation);
        s1_side_next.amp_a      = s_amp_a;
        s1_side_next.freq_a     = s_freq_a;
        s1_side_next.phase_a    = s_phase_a;
        s1_side_next.mismatch   = s_freq_a != s_freq_b;
        s1_side_next.neg_factor = s_factor[23];
        s1_side_next.amp_a_nz   = s_amp_a != 24'd0;
        s1_side_next.mag_zero   = s1_mag_next == 24'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg    <= s1_side_next;
            s1_comp_a_reg  <= s1_comp_a_next;
            s1_comp_b_reg  <= s1_comp_b_next;
            s1_phase_b_reg <= s1_phase_b_next;
            s1_ftp_reg     <= 56'(s_freq_a) * 56'(s_time_point);
            s1_sprod_reg   <= 48'(s_amp_a) * 48'(s1_mag_next);
            s1_num_reg     <= s1_num_next;
            s1_mag_reg     <= s1_mag_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: partial products of w*t times 1/(2*pi); rounding of scale.
    // ------------------------------------------------------------------
    logic            s2_valid_reg;
    side_t           s2_side_reg, s2_side_next;
    logic [59:0]     s2_ll_reg, s2_lh_reg, s2_hl_reg, s2_hh_reg;
    logic [CW-1:0]   s2_comp_a_reg, s2_comp_b_reg;
    logic [15:0]     s2_phase_b_reg;
    logic [NUMW-1:0] s2_num_reg;
    logic [23:0]     s2_mag_reg;
    logic [48:0]     sc_sum, sc_q;

    always_comb begin
        sc_sum = {1'b0, s1_sprod_reg} + (49'd1 << (FRAC_BITS - 1));
        sc_q   = sc_sum >> FRAC_BITS;
        s2_side_next           = s1_side_reg;
        s2_side_next.scale_amp = sc_q[23:0];
        s2_side_next.scale_sat = |sc_q[48:24];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg    <= s2_side_next;
            s2_ll_reg      <= 60'(s1_ftp_reg[27:0]) * 60'(RECIP_TWO_PI[31:0]);
            s2_lh_reg      <= 60'(s1_ftp_reg[27:0]) * 60'(RECIP_TWO_PI[63:32]);
            s2_hl_reg      <= 60'(s1_ftp_reg[55:28]) * 60'(RECIP_TWO_PI[31:0]);
            s2_hh_reg      <= 60'(s1_ftp_reg[55:28]) * 60'(RECIP_TWO_PI[63:32]);
            s2_comp_a_reg  <= s1_comp_a_reg;
            s2_comp_b_reg  <= s1_comp_b_reg;
            s2_phase_b_reg <= s1_phase_b_reg;
            s2_num_reg     <= s1_num_reg;
            s2_mag_reg     <= s1_mag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: two partial sums of the wide product.
    // ------------------------------------------------------------------
    logic            s3_valid_reg;
    side_t           s3_side_reg;
    logic [PW-1:0]   s3_p1_reg, s3_p2_reg;
    logic [CW-1:0]   s3_comp_a_reg, s3_comp_b_reg;
    logic [15:0]     s3_phase_b_reg;
    logic [NUMW-1:0] s3_num_reg;
    logic [23:0]     s3_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_side_reg    <= s2_side_reg;
            s3_p1_reg      <= PW'(s2_ll_reg) + (PW'(s2_lh_reg) << 32);
            s3_p2_reg      <= (PW'(s2_hl_reg) << 28) + (PW'(s2_hh_reg) << 60);
            s3_comp_a_reg  <= s2_comp_a_reg;
            s3_comp_b_reg  <= s2_comp_b_reg;
            s3_phase_b_reg <= s2_phase_b_reg;
            s3_num_reg     <= s2_num_reg;
            s3_mag_reg     <= s2_mag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final sum; w*t reduced to a 32-bit binary angle.
    // ------------------------------------------------------------------
    logic            s4_valid_reg;
    side_t           s4_side_reg;
    logic [31:0]     s4_turns_reg;
    logic [CW-1:0]   s4_comp_a_reg, s4_comp_b_reg;
    logic [15:0]     s4_phase_b_reg;
    logic [NUMW-1:0] s4_num_reg;
    logic [23:0]     s4_mag_reg;
    logic [PW-1:0]   psum;

    assign psum = s3_p1_reg + s3_p2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_side_reg    <= s3_side_reg;
            s4_turns_reg   <= psum[TURN_LSB +: 32];
            s4_comp_a_reg  <= s3_comp_a_reg;
            s4_comp_b_reg  <= s3_comp_b_reg;
            s4_phase_b_reg <= s3_phase_b_reg;
            s4_num_reg     <= s3_num_reg;
            s4_mag_reg     <= s3_mag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: rotation angles and the half-turn pre-rotation that brings
    // each angle into the CORDIC's convergence range.
    // ------------------------------------------------------------------
    logic                 s5_valid_reg;
    side_t                s5_side_reg;
    logic signed [XW-1:0] s5_xa_reg, s5_xb_reg, xa_next, xb_next;
    logic [31:0]          s5_za_reg, s5_zb_reg, za_next, zb_next, ang_a, ang_b;
    logic [NUMW-1:0]      s5_num_reg;
    logic [23:0]          s5_mag_reg;
    logic signed [XW-1:0] comp_a_s, comp_b_s;

    always_comb begin
        ang_a = {s4_side_reg.phase_a, 16'h0000};
        if (s4_side_reg.op == OP_EVAL) begin
            ang_a = s4_turns_reg + ang_a;
        end
        ang_b    = {s4_phase_b_reg, 16'h0000};
        comp_a_s = $signed({{(XW - CW){1'b0}}, s4_comp_a_reg});
        comp_b_s = $signed({{(XW - CW){1'b0}}, s4_comp_b_reg});
        if ($signed(ang_a) > QUARTER_TURN || $signed(ang_a) < NEG_QUARTER_TURN) begin
            xa_next = -comp_a_s;
            za_next = ang_a + HALF_TURN;
        end else begin
            xa_next = comp_a_s;
            za_next = ang_a;
        end
        if ($signed(ang_b) > QUARTER_TURN || $signed(ang_b) < NEG_QUARTER_TURN) begin
            xb_next = -comp_b_s;
            zb_next = ang_b + HALF_TURN;
        end else begin
            xb_next = comp_b_s;
            zb_next = ang_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_side_reg <= s4_side_reg;
            s5_xa_reg   <= xa_next;
            s5_za_reg   <= za_next;
            s5_xb_reg   <= xb_next;
            s5_zb_reg   <= zb_next;
            s5_num_reg  <= s4_num_reg;
            s5_mag_reg  <= s4_mag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Main chain: N rotation stages, sum, vector set-up, N vector stages and
    // the gain multiply. The side information and valid bits follow along,
    // and the divider runs one stage per position beside them.
    // ------------------------------------------------------------------
    side_t             side_reg [DIV_ST];
    logic [DIV_ST-1:0] vld_reg;
    side_t             sum_side;

    logic signed [XW-1:0] rxa [N];
    logic signed [XW-1:0] rya [N];
    logic [31:0]          rza [N];
    logic signed [XW-1:0] rxb [N];
    logic signed [XW-1:0] ryb [N];
    logic [31:0]          rzb [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_rot
            if (k == 0) begin : g_first
                spa_rot_stage #(.IDX(k)) u_rot_a (
                    .aclk(aclk), .en(en),
                    .x_in(s5_xa_reg), .y_in('0), .z_in(s5_za_reg),
                    .x_reg(rxa[k]), .y_reg(rya[k]), .z_reg(rza[k])
                );
                spa_rot_stage #(.IDX(k)) u_rot_b (
                    .aclk(aclk), .en(en),
                    .x_in(s5_xb_reg), .y_in('0), .z_in(s5_zb_reg),
                    .x_reg(rxb[k]), .y_reg(ryb[k]), .z_reg(rzb[k])
                );
            end else begin : g_next
                spa_rot_stage #(.IDX(k)) u_rot_a (
                    .aclk(aclk), .en(en),
                    .x_in(rxa[k-1]), .y_in(rya[k-1]), .z_in(rza[k-1]),
                    .x_reg(rxa[k]), .y_reg(rya[k]), .z_reg(rza[k])
                );
                spa_rot_stage #(.IDX(k)) u_rot_b (
                    .aclk(aclk), .en(en),
                    .x_in(rxb[k-1]), .y_in(ryb[k-1]), .z_in(rzb[k-1]),
                    .x_reg(rxb[k]), .y_reg(ryb[k]), .z_reg(rzb[k])
                );
            end
        end
    endgenerate

    // Sum of the two phasors, and the rounded and clamped sample of evaluate,
    // which is the sine part of the first rotation.
    logic signed [XW-1:0] sum_x_reg, sum_y_reg, sum_x_next, sum_y_next;
    logic signed [XW-1:0] samp_round, samp_shift;

    always_comb begin
        sum_x_next = rxa[N-1] + rxb[N-1];
        sum_y_next = rya[N-1] + ryb[N-1];
        samp_round = rya[N-1] + XW'(32'sd1 <<< (GUARD - 1));
        samp_shift = samp_round >>> GUARD;
        sum_side   = side_reg[N-1];
        sum_side.sum_zero   = sum_x_next == '0 && sum_y_next == '0;
        sum_side.sample_sat = 1'b0;
        if (samp_shift > XW'(36'sd16777215)) begin
            sum_side.sample     = 25'sd16777215;
            sum_side.sample_sat = 1'b1;
        end else if (samp_shift < -XW'(36'sd16777216)) begin
            sum_side.sample     = -25'sd16777216;
            sum_side.sample_sat = 1'b1;
        end else begin
            sum_side.sample = samp_shift[24:0];
        end
    end

    // Vector set-up: fold the left half-plane onto the right.
    logic signed [XW-1:0] pre_x_reg, pre_y_reg;
    logic [31:0]          pre_z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            if (sum_x_reg[XW-1]) begin
                pre_x_reg <= -sum_x_reg;
                pre_y_reg <= -sum_y_reg;
                pre_z_reg <= HALF_TURN;
            end else begin
                pre_x_reg <= sum_x_reg;
                pre_y_reg <= sum_y_reg;
                pre_z_reg <= '0;
            end
        end
    end

    logic signed [XW-1:0] vx [N];
    logic signed [XW-1:0] vy [N];
    logic [31:0]          vz [N];

    generate
        for (k = 0; k < N; k++) begin : g_vec
            if (k == 0) begin : g_first
                spa_vec_stage #(.IDX(k)) u_vec (
                    .aclk(aclk), .en(en),
                    .x_in(pre_x_reg), .y_in(pre_y_reg), .z_in(pre_z_reg),
                    .x_reg(vx[k]), .y_reg(vy[k]), .z_reg(vz[k])
                );
            end else begin : g_next
                spa_vec_stage #(.IDX(k)) u_vec (
                    .aclk(aclk), .en(en),
                    .x_in(vx[k-1]), .y_in(vy[k-1]), .z_in(vz[k-1]),
                    .x_reg(vx[k]), .y_reg(vy[k]), .z_reg(vz[k])
                );
            end
        end
    endgenerate

    // Gain removal multiply on the vector magnitude.
    logic [61:0] mul_prod_reg;
    logic [31:0] mul_z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_prod_reg <= 62'(vx[N-1][31:0]) * 62'(INV_GAIN);
            mul_z_reg    <= vz[N-1];
        end
    end

    // Divider chain, aligned with the side pipeline position by position.
    logic [DIV_W-1:0] drem [DIV_ST];
    logic [QB-1:0]    dnq  [DIV_ST];
    logic [DIV_W-1:0] dd   [DIV_ST];

    generate
        for (k = 0; k < DIV_ST; k++) begin : g_div
            if (k == 0) begin : g_first
                spa_div_stage #(.QB(QB), .BPS(BPS)) u_div (
                    .aclk(aclk), .en(en),
                    .rem_in('0), .nq_in(QB'(s5_num_reg)), .d_in(s5_mag_reg),
                    .rem_reg(drem[k]), .nq_reg(dnq[k]), .d_reg(dd[k])
                );
            end else begin : g_next
                spa_div_stage #(.QB(QB), .BPS(BPS)) u_div (
                    .aclk(aclk), .en(en),
                    .rem_in(drem[k-1]), .nq_in(dnq[k-1]), .d_in(dd[k-1]),
                    .rem_reg(drem[k]), .nq_reg(dnq[k]), .d_reg(dd[k])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_ST-2:0], s5_valid_reg};
        end
    end

    // Position N takes the side word that carries the phasor sum and sample.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= s5_side_reg;
            for (int i = 1; i < DIV_ST; i++) begin
                if (i != N) begin
                    side_reg[i] <= side_reg[i-1];
                end
            end
            side_reg[N] <= sum_side;
        end
    end

    // ------------------------------------------------------------------
    // Final stage: rounding, saturation, phase flip and result selection into
    // the output register.
    // ------------------------------------------------------------------
    side_t              fin;
    logic [62:0]        vec_round;
    logic [26:0]        vec_amp;
    logic [31:0]        vec_phase_sum;
    logic [QB-1:0]      quot;
    logic [23:0]        amp_next;
    logic [15:0]        phase_next, phase_flip;
    logic signed [24:0] sample_next;
    status_t            status_next;

    logic [23:0]        m_amp_reg, m_freq_reg;
    logic [15:0]        m_phase_reg;
    logic signed [24:0] m_sample_reg;
    status_t            m_status_reg;

    always_comb begin
        fin           = side_reg[DIV_ST-1];
        vec_round     = {1'b0, mul_prod_reg} + (63'd1 << (29 + GUARD));
        vec_amp       = vec_round[62:36];
        vec_phase_sum = mul_z_reg + 32'h00008000;
        quot          = dnq[DIV_ST-1];
        phase_flip    = fin.phase_a ^ 16'h8000;

        amp_next    = fin.amp_a;
        phase_next  = fin.phase_a;
        sample_next = '0;
        status_next = ST_OK;
        case (fin.op)
            OP_ADD, OP_SUB: begin
                if (fin.mismatch) begin
                    status_next = ST_MISMATCH;
                end else if (fin.sum_zero) begin
                    amp_next   = '0;
                    phase_next = '0;
                end else begin
                    phase_next = vec_phase_sum[31:16];
                    if (|vec_amp[26:24]) begin
                        amp_next    = AMP_MAX;
                        status_next = ST_SAT;
                    end else begin
                        amp_next = vec_amp[23:0];
                    end
                end
            end
            OP_SCALE: begin
                if (fin.scale_sat) begin
                    amp_next    = AMP_MAX;
                    status_next = ST_SAT;
                end else begin
                    amp_next = fin.scale_amp;
                end
                if (fin.neg_factor && fin.amp_a_nz) begin
                    phase_next = phase_flip;
                end
            end
            OP_DIV: begin
                if (fin.mag_zero) begin
                    status_next = ST_DIVZERO;
                end else begin
                    if (|quot[QB-1:24]) begin
                        amp_next    = AMP_MAX;
                        status_next = ST_SAT;
                    end else begin
                        amp_next = quot[23:0];
                    end
                    if (fin.neg_factor && fin.amp_a_nz) begin
                        phase_next = phase_flip;
                    end
                end
            end
            OP_NEG: begin
                if (fin.amp_a_nz) begin
                    phase_next = phase_flip;
                end
            end
            OP_EVAL: begin
                sample_next = fin.sample;
                if (fin.sample_sat) begin
                    status_next = ST_SAT;
                end
            end
            default: begin
                amp_next = fin.amp_a;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[DIV_ST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_amp_reg    <= amp_next;
            m_freq_reg   <= fin.freq_a;
            m_phase_reg  <= phase_next;
            m_sample_reg <= sample_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_amp_out      = m_amp_reg;
    assign m_freq_out     = m_freq_reg;
    assign m_phase_out    = m_phase_reg;
    assign m_sample_value = m_sample_reg;
    assign m_status       = m_status_reg;

endmodule
